[rtl/level_display_hysteresis_assert.svh]
// assertion macros for the level display hysteresis block
// expects a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef LEVEL_DISPLAY_HYSTERESIS_ASSERT_SVH
`define LEVEL_DISPLAY_HYSTERESIS_ASSERT_SVH

// consequent holds in the same cycle
`define LDH_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("level_display_hysteresis: same-cycle check failed");

// consequent holds in the next cycle
`define LDH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("level_display_hysteresis: next-cycle check failed");

`endif

[rtl/ldh_pkg.sv]
// package for the level display hysteresis block
// action codes, widths and rounding constants, no dependencies
package ldh_pkg;

    localparam int LEVEL_W = 16;
    localparam int DB_W    = 13;
    localparam int HYST_W  = 7;
    localparam int THR_W   = HYST_W + 1;

    localparam logic [HYST_W-1:0] HYST_RESET     = 7'd5;
    localparam logic [3:0]        HALF_DB_TENTHS = 4'd5;
    localparam logic [3:0]        TENTHS_PER_DB  = 4'd10;

    // x / 10 == (x * 52429) >> 19 for every 16-bit unsigned x
    localparam logic [15:0] DIV10_RECIP = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef enum logic [1:0] {
        ACT_LEVEL   = 2'd0,
        ACT_STATION = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

endpackage

[rtl/level_display_hysteresis.sv]
// top level of the level display hysteresis block
// uses ldh_pkg, ldh_round and the assertion macro header
// A level reading (action 0) turns a signal level in tenths of a dB into the whole-dB value to
// show and gives one result; station change (action 1), clear (action 2) and the unused code
// give none. Each transfer passes an input register and the rounding and hysteresis logic into
// the result register; one item is taken every cycle unless a level reading waits on a stalled
// result. The display state is updated as the item leaves the input register, so the next
// item sees it at once. The hysteresis register is written through a port that is always
// ready and takes effect for items that reach the logic after the write.
`include "level_display_hysteresis_assert.svh"

module level_display_hysteresis
    import ldh_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_action,
    input  logic signed [LEVEL_W-1:0] i_level_tenths,
    input  logic                      i_fresh,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [DB_W-1:0]    o_shown_db,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [HYST_W-1:0]         i_cfg_data
);

    logic                      r_in_valid;
    t_action                   r_in_action;
    logic signed [LEVEL_W-1:0] r_in_level;
    logic                      r_in_fresh;

    logic [HYST_W-1:0]         r_hyst;
    logic signed [DB_W-1:0]    r_disp;
    logic                      r_started;
    logic                      r_await;
    logic                      r_out_valid;
    logic signed [DB_W-1:0]    r_out_db;

    logic signed [DB_W-1:0]    n_disp;
    logic                      n_started;
    logic                      n_await;
    logic signed [DB_W-1:0]    shown;

    logic signed [DB_W-1:0]    rounded;
    logic                      out_block;
    logic                      produces;
    logic                      adv;
    logic                      in_xfer;
    logic signed [LEVEL_W+1:0] disp_ext;
    logic signed [LEVEL_W+1:0] diff;
    logic [LEVEL_W+1:0]        away;
    logic [THR_W-1:0]          thr;

    ldh_round u_round (
        .i_level_tenths (r_in_level),
        .o_db           (rounded)
    );

    always_comb begin
        out_block  = r_out_valid && i_out_stall;
        produces   = (r_in_action == ACT_LEVEL);
        adv        = r_in_valid && (!produces || !out_block);
        o_in_stall = r_in_valid && !adv;
        in_xfer    = i_in_valid && !o_in_stall;
        o_cfg_ready = 1'b1;
        o_out_valid = r_out_valid;
        o_shown_db  = r_out_db;
    end

    // distance of the level from the shown digit, in tenths
    always_comb begin
        disp_ext = (LEVEL_W+2)'(r_disp);
        diff     = (LEVEL_W+2)'(r_in_level) - ((disp_ext <<< 3) + (disp_ext <<< 1));
        away     = diff[LEVEL_W+1] ? (LEVEL_W+2)'(-diff) : diff;
        thr      = THR_W'(HALF_DB_TENTHS) + THR_W'(r_hyst);
    end

    always_comb begin
        n_disp    = r_disp;
        n_started = r_started;
        n_await   = r_await;
        shown     = r_disp;
        unique case (r_in_action)
            ACT_LEVEL: begin
                if (r_await && !r_in_fresh) begin
                    shown = r_started ? r_disp : rounded;
                end else begin
                    n_await = 1'b0;
                    if (!r_started || r_await) begin
                        n_started = 1'b1;
                        n_disp    = rounded;
                    end else if (away >= (LEVEL_W+2)'(thr)) begin
                        n_disp = rounded;
                    end
                    shown = n_disp;
                end
            end
            ACT_STATION: begin
                n_await = 1'b1;
            end
            ACT_CLEAR: begin
                n_disp    = '0;
                n_started = 1'b0;
                n_await   = 1'b0;
            end
            ACT_NONE: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_hyst      <= HYST_RESET;
            r_disp      <= '0;
            r_started   <= 1'b0;
            r_await     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_hyst <= i_cfg_data;
            end
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_disp    <= n_disp;
                r_started <= n_started;
                r_await   <= n_await;
            end
            if (adv && produces) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_action <= t_action'(i_action);
            r_in_level  <= i_level_tenths;
            r_in_fresh  <= i_fresh;
        end
        if (adv && produces) begin
            r_out_db <= shown;
        end
    end

    `LDH_ASSERT_SAME(a_idle_disp_zero, !r_started, r_disp == '0)
    `LDH_ASSERT_NEXT(a_station_sets_wait, adv && r_in_action == ACT_STATION, r_await)
    `LDH_ASSERT_NEXT(a_level_gives_result, adv && r_in_action == ACT_LEVEL, o_out_valid)
    `LDH_ASSERT_SAME(a_stall_only_on_block, o_in_stall, r_in_valid && o_out_valid && i_out_stall)

endmodule

[rtl/ldh_round.sv]
// rounds a level in tenths of a dB to the nearest whole dB, halves away from zero
// uses ldh_pkg for widths and the divide-by-ten reciprocal
module ldh_round
    import ldh_pkg::*;
(
    input  logic signed [LEVEL_W-1:0] i_level_tenths,
    output logic signed [DB_W-1:0]    o_db
);

    logic                 neg;
    logic [LEVEL_W:0]     lvl_ext;
    logic [LEVEL_W:0]     mag;
    logic [LEVEL_W-1:0]   biased;
    logic [2*LEVEL_W-1:0] prod;
    logic [DB_W-2:0]      quot;

    always_comb begin
        neg     = i_level_tenths[LEVEL_W-1];
        lvl_ext = {i_level_tenths[LEVEL_W-1], i_level_tenths};
        mag     = neg ? (LEVEL_W+1)'(-lvl_ext) : lvl_ext;
        // magnitude never exceeds 32768, so the bias fits in 16 bits
        biased  = mag[LEVEL_W-1:0] + LEVEL_W'(HALF_DB_TENTHS);
        prod    = (2*LEVEL_W)'(biased) * (2*LEVEL_W)'(DIV10_RECIP);
        quot    = prod[DIV10_SHIFT +: (DB_W-1)];
        o_db    = neg ? DB_W'(-$signed({1'b0, quot})) : $signed({1'b0, quot});
    end

endmodule
